/* hw/rtl/pcmmm_pkg.sv */
// Package for the per-channel min/max/mean statistics block.
// Holds field widths, opcodes, register indexes and shared structs.
// No dependencies.
package pcmmm_pkg;

  localparam int unsigned ValueW   = 20;
  localparam int unsigned TimeW    = 17;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned SumW     = 36;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DefChannels = 16;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [ValueW-1:0] LowReset  = 20'd9000;
  localparam logic [ValueW-1:0] HighReset = 20'd16000;
  localparam logic [CountW-1:0] CountMax  = '1;

  typedef enum logic {
    OpRecord = 1'b0,
    OpRead   = 1'b1
  } op_e;

  typedef enum logic {
    RegLowLimit  = 1'b0,
    RegHighLimit = 1'b1
  } reg_idx_e;

  // One classified command handed from the front to the back.
  typedef struct packed {
    op_e               op;
    logic              in_range;
    logic [ChanW-1:0]  chan;
    logic              win_ok;
    logic [ValueW-1:0] value;
    logic [TimeW-1:0]  stamp;
  } cmd_t;

  // Statistics snapshot handed to the divider stage.
  typedef struct packed {
    logic [ChanW-1:0]  chan;
    logic              has_data;
    logic [ValueW-1:0] min_value;
    logic [TimeW-1:0]  min_time;
    logic [ValueW-1:0] max_value;
    logic [TimeW-1:0]  max_time;
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
  } snap_t;

  typedef enum logic [1:0] {
    DivIdle,
    DivRun,
    DivDone
  } div_state_e;

endpackage

/* hw/rtl/pcmmm_front.sv */
// Front end: accepts input beats, checks window and channel range, and
// pushes classified commands into a small queue. Depends on pcmmm_pkg.
module pcmmm_front import pcmmm_pkg::*; #(
  parameter int unsigned Channels = DefChannels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic              op_i,
  input  logic [ChanW-1:0]  chan_i,
  input  logic [ValueW-1:0] value_i,
  input  logic [TimeW-1:0]  stamp_i,
  input  logic [ValueW-1:0] low_limit_i,
  input  logic [ValueW-1:0] high_limit_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  cmd_t            cmd_in;
  logic            push, pop;

  assign s_tready_o  = (cnt_q != (PtrW+1)'(QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign push        = s_tvalid_i && s_tready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cmd_in.op       = op_e'(op_i);
    cmd_in.in_range = (32'(chan_i) < Channels);
    cmd_in.chan     = chan_i;
    cmd_in.win_ok   = (value_i >= low_limit_i) && (value_i <= high_limit_i);
    cmd_in.value    = value_i;
    cmd_in.stamp    = stamp_i;
  end

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop)
    else $error("pop from empty queue");

endmodule

/* hw/rtl/pcmmm_back.sv */
// Back end: per-channel statistic registers updated by
// read-modify-write, plus a bit-serial divider for reads. Depends on pcmmm_pkg.
module pcmmm_back import pcmmm_pkg::*; #(
  parameter int unsigned Channels = DefChannels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output snap_t             res_o,
  output logic [ValueW-1:0] mean_o
);

  localparam int unsigned IdxW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [ValueW-1:0] minv_q [Channels];
  logic [TimeW-1:0]  mint_q [Channels];
  logic [ValueW-1:0] maxv_q [Channels];
  logic [TimeW-1:0]  maxt_q [Channels];
  logic [SumW-1:0]   sum_q  [Channels];
  logic [CountW-1:0] cnt_q  [Channels];

  logic [IdxW-1:0]   idx;
  logic              take, rec;
  div_state_e        st_q, st_d;
  snap_t             snap_q;
  logic [SumW-1:0]   quo_q, quo_d;
  logic [CountW:0]   rem_q, rem_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CountW:0]   trial;
  logic              load;

  assign idx  = IdxW'(cmd_i.chan);
  assign take = cmd_valid_i && cmd_ready_o;
  assign rec  = take && (cmd_i.op == OpRecord) && cmd_i.in_range && cmd_i.win_ok;
  assign load = take && (cmd_i.op == OpRead);

  // Records flow every cycle; a read holds the back end until its result leaves.
  assign cmd_ready_o = (st_q == DivIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < Channels; c++) begin
        minv_q[c] <= '0;
        mint_q[c] <= '0;
        maxv_q[c] <= '0;
        maxt_q[c] <= '0;
        sum_q[c]  <= '0;
        cnt_q[c]  <= '0;
      end
    end else if (rec) begin
      if (cnt_q[idx] == '0) begin
        minv_q[idx] <= cmd_i.value;
        mint_q[idx] <= cmd_i.stamp;
        maxv_q[idx] <= cmd_i.value;
        maxt_q[idx] <= cmd_i.stamp;
      end else begin
        if (cmd_i.value < minv_q[idx] ||
            (cmd_i.value == minv_q[idx] && cmd_i.stamp < mint_q[idx])) begin
          minv_q[idx] <= cmd_i.value;
          mint_q[idx] <= cmd_i.stamp;
        end
        if (cmd_i.value > maxv_q[idx] ||
            (cmd_i.value == maxv_q[idx] && cmd_i.stamp < maxt_q[idx])) begin
          maxv_q[idx] <= cmd_i.value;
          maxt_q[idx] <= cmd_i.stamp;
        end
      end
      if (cnt_q[idx] != CountMax) begin
        sum_q[idx] <= sum_q[idx] + SumW'(cmd_i.value);
        cnt_q[idx] <= cnt_q[idx] + 1'b1;
      end
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      DivIdle: if (load) st_d = DivRun;
      DivRun:  if (step_q == StepW'(SumW - 1)) st_d = DivDone;
      DivDone: if (res_ready_i) st_d = DivIdle;
      default: st_d = DivIdle;
    endcase
  end

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem_q[CountW-1:0], quo_q[SumW-1]};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (load) begin
      quo_d  = (cmd_i.in_range && cnt_q[idx] != '0) ? sum_q[idx] : '0;
      rem_d  = '0;
      step_d = '0;
    end else if (st_q == DivRun) begin
      step_d = step_q + 1'b1;
      if (trial >= {1'b0, snap_q.count}) begin
        rem_d = trial - {1'b0, snap_q.count};
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DivIdle;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (load) begin
      snap_q.chan     <= cmd_i.chan;
      if (cmd_i.in_range && cnt_q[idx] != '0) begin
        snap_q.has_data  <= 1'b1;
        snap_q.min_value <= minv_q[idx];
        snap_q.min_time  <= mint_q[idx];
        snap_q.max_value <= maxv_q[idx];
        snap_q.max_time  <= maxt_q[idx];
        snap_q.sum       <= sum_q[idx];
        snap_q.count     <= cnt_q[idx];
      end else begin
        snap_q.has_data  <= 1'b0;
        snap_q.min_value <= '0;
        snap_q.min_time  <= '0;
        snap_q.max_value <= '0;
        snap_q.max_time  <= '0;
        snap_q.sum       <= '0;
        // The quotient of an empty channel is meaningless; mean_o masks it to zero.
        snap_q.count     <= '0;
      end
    end
  end

  assign res_valid_o = (st_q == DivDone);
  assign res_o       = snap_q;
  assign mean_o      = snap_q.has_data ? quo_q[ValueW-1:0] : '0;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !cmd_ready_o)
    else $error("back end took a command while a result waits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> res_valid_o && $stable(mean_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> st_q == DivRun)
    else $error("read did not start the divider");

endmodule

/* hw/rtl/per_channel_min_max_mean.sv */
// Top level of the per-channel min/max/mean statistics block.
// Instantiates pcmmm_front and pcmmm_back; uses pcmmm_pkg.
//
// Use: input beats on s_axis carry opcode, channel, value and time. A record
// beat updates that channel's minimum, maximum, sum and count when the value
// lies inside [low_limit, high_limit]; it gives no output. A read beat gives
// one output beat on m_axis with the channel's statistics and floor(sum/count).
// Record beats are taken one per cycle while the queue has room and update at
// the edge they leave the four-entry command queue, which a read in progress can
// delay. A read holds the back end while it snapshots the channel, runs the
// bit-serial divider (one quotient bit a cycle over the 36-bit sum) and presents
// the result, held in its register until m_axis_tready; meanwhile the queue keeps
// taking beats until it is full. Configuration writes on cfg (index 0 low_limit,
// index 1 high_limit) are taken at once, every cycle. Reset clears all
// statistics, the queue and the limits (9000 and 16000) at once; no clearing pass.
module per_channel_min_max_mean import pcmmm_pkg::*; #(
  parameter int unsigned Channels = DefChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,  // opcode
  input  logic [47:0] s_axis_tdata,  // channel_id, sample_value, sample_time
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [119:0] m_axis_tdata, // out_channel, has_data, min_value,
                                     // min_time, max_value, max_time,
                                     // mean_value, sample_count
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [ValueW-1:0] cfg_data_i
);

  logic [ValueW-1:0] low_q, high_q;
  logic              cmd_valid, cmd_ready;
  cmd_t              cmd;
  snap_t             res;
  logic [ValueW-1:0] mean;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LowReset;
      high_q <= HighReset;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegLowLimit:  low_q  <= cfg_data_i;
        RegHighLimit: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcmmm_front #(.Channels(Channels)) u_front (
    .clk_i,
    .rst_ni,
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .chan_i       (s_axis_tdata[3:0]),
    .value_i      (s_axis_tdata[23:4]),
    .stamp_i      (s_axis_tdata[40:24]),
    .low_limit_i  (low_q),
    .high_limit_i (high_q),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  pcmmm_back #(.Channels(Channels)) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res),
    .mean_o      (mean)
  );

  assign m_axis_tdata = {5'b0, res.count, mean, res.max_time, res.max_value,
                         res.min_time, res.min_value, res.has_data, res.chan};

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for per_channel_min_max_mean.
// Drives record and read beats, predicts each read result and checks m_axis.
// Depends on pcmmm_pkg and the per_channel_min_max_mean RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcmmm_pkg::*;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [ValueW-1:0] mean;
    logic [TimeW-1:0]  max_time;
    logic [ValueW-1:0] max_value;
    logic [TimeW-1:0]  min_time;
    logic [ValueW-1:0] min_value;
    logic              has_data;
    logic [ChanW-1:0]  chan;
  } stats_t;

  // Mirrors the channel statistics and holds the reads still owed.
  class stats_board;
    logic [ValueW-1:0] low_lim, high_lim;
    logic [ValueW-1:0] lo_v [DefChannels];
    logic [TimeW-1:0]  lo_t [DefChannels];
    logic [ValueW-1:0] hi_v [DefChannels];
    logic [TimeW-1:0]  hi_t [DefChannels];
    logic [SumW-1:0]   sum  [DefChannels];
    logic [CountW-1:0] cnt  [DefChannels];
    stats_t pending[$];
    int errors;

    function new();
      low_lim = LowReset;
      high_lim = HighReset;
      errors = 0;
      for (int c = 0; c < DefChannels; c++) begin
        lo_v[c] = '0; lo_t[c] = '0; hi_v[c] = '0; hi_t[c] = '0;
        sum[c] = '0; cnt[c] = '0;
      end
    endfunction

    function void note_beat(op_e op, logic [ChanW-1:0] ch, logic [ValueW-1:0] v,
                            logic [TimeW-1:0] t);
      stats_t s;
      if (op == OpRecord) begin
        if (v < low_lim || v > high_lim) return;
        if (cnt[ch] == 0) begin
          lo_v[ch] = v; lo_t[ch] = t; hi_v[ch] = v; hi_t[ch] = t;
        end else begin
          if (v < lo_v[ch] || (v == lo_v[ch] && t < lo_t[ch])) begin
            lo_v[ch] = v; lo_t[ch] = t;
          end
          if (v > hi_v[ch] || (v == hi_v[ch] && t < hi_t[ch])) begin
            hi_v[ch] = v; hi_t[ch] = t;
          end
        end
        if (cnt[ch] != CountMax) begin
          sum[ch] = sum[ch] + SumW'(v);
          cnt[ch] = cnt[ch] + 1'b1;
        end
        return;
      end
      s = '0;
      s.chan = ch;
      if (cnt[ch] != 0) begin
        s.has_data = 1'b1;
        s.min_value = lo_v[ch]; s.min_time = lo_t[ch];
        s.max_value = hi_v[ch]; s.max_time = hi_t[ch];
        s.mean = ValueW'(sum[ch] / cnt[ch]);
        s.count = cnt[ch];
      end
      pending = {pending, s};
    endfunction

    function void check_result(stats_t got);
      stats_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch ch %0d: exp hd=%0d min=%0d@%0d max=%0d@%0d mean=%0d n=%0d;",
                   want.chan, want.has_data, want.min_value, want.min_time,
                   want.max_value, want.max_time, want.mean, want.count,
                   " got ch=%0d hd=%0d min=%0d@%0d max=%0d@%0d mean=%0d n=%0d",
                   got.chan, got.has_data, got.min_value, got.min_time,
                   got.max_value, got.max_time, got.mean, got.count);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic s_axis_tuser = 1'b0;          // opcode
  logic [47:0] s_axis_tdata = '0;     // channel_id, sample_value, sample_time
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;         // out_channel .. sample_count
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [ValueW-1:0] cfg_data_i = '0;

  stats_board board = new();
  int unsigned cycles = 0;
  bit stall_mode = 1'b0;

  always #2 clk_i = ~clk_i;

  per_channel_min_max_mean DUT (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver: checks accepted results and stalls on its own pattern while stall_mode is set.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(stats_t'(m_axis_tdata[114:0]));
    if (!stall_mode) m_axis_tready <= 1'b1;
    else m_axis_tready <= (cycles % 7 < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  int burst = 0;

  task automatic send(op_e op, logic [ChanW-1:0] ch, logic [ValueW-1:0] v,
                      logic [TimeW-1:0] t);
    int gap;
    if (burst == 0) begin
      burst = $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'b0, t, v, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_beat(op, ch, v, t);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [ValueW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegLowLimit) board.low_lim = val; else board.high_lim = val;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n, logic [ValueW-1:0] lo, logic [ValueW-1:0] hi);
    logic [ValueW-1:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: v = ValueW'($urandom());
        1: v = lo;
        2: v = hi;
        default: v = ValueW'($urandom_range(lo, hi));
      endcase
      send($urandom_range(0, 3) == 0 ? OpRead : OpRecord,
           ChanW'($urandom_range(0, 15)), v,
           $urandom_range(0, 3) == 0 ? TimeW'($urandom()) :
                                       TimeW'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty read, first sample, ties, window edges, out-of-window.
    send(OpRead, 4'd0, '0, '0);
    send(OpRecord, 4'd0, 20'd12000, 17'd500);
    send(OpRead, 4'd0, '0, '0);
    send(OpRecord, 4'd0, 20'd12000, 17'd100);
    send(OpRecord, 4'd0, 20'd9000, 17'd86399);
    send(OpRecord, 4'd0, 20'd16000, 17'h1FFFF);
    send(OpRecord, 4'd0, 20'd16000, 17'd3);
    send(OpRecord, 4'd0, 20'd8999, 17'd0);
    send(OpRecord, 4'd0, 20'd16001, 17'd0);
    send(OpRecord, 4'd0, 20'hFFFFF, 17'd1);
    send(OpRead, 4'd0, 20'hFFFFF, 17'h1FFFF);
    send(OpRecord, 4'd15, 20'd9000, 17'd0);
    send(OpRead, 4'd15, '0, '0);
    drain();
    stall_mode = 1'b1;
    random_phase(150, 20'd9000, 20'd16000);
    drain();
    write_reg(RegLowLimit, '0);
    write_reg(RegHighLimit, 20'hFFFFF);
    send(OpRecord, 4'd3, '0, '0);
    send(OpRecord, 4'd3, 20'hFFFFF, 17'h1FFFF);
    send(OpRead, 4'd3, '0, '0);
    random_phase(120, 20'd0, 20'hFFFFF);
    drain();
    write_reg(RegLowLimit, 20'd500);
    write_reg(RegHighLimit, 20'd100);
    random_phase(40, 20'd0, 20'd1000);
    drain();
    write_reg(RegLowLimit, 20'd5);
    write_reg(RegHighLimit, 20'd9);
    stall_mode = 1'b0;
    // A run of records on channel 7 with many ties, then a read of it.
    for (int i = 0; i < 40; i++)
      send(OpRecord, 4'd7, ValueW'($urandom_range(5, 9)), TimeW'($urandom_range(0, 3)));
    send(OpRead, 4'd7, '0, '0);
    stall_mode = 1'b1;
    random_phase(150, 20'd5, 20'd9);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
